// ===== rtl/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

  localparam int TCW_ROWS        = 25;
  localparam int TCW_COLS        = 80;
  localparam int TCW_QUEUE_DEPTH = 2;

  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int CELL_W   = 16;
  localparam int ATTR_W   = 8;

  localparam logic [CELL_W-1:0] RESET_CELL  = 16'h1f20;
  localparam logic [CHAR_W-1:0] BLANK_GLYPH = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h1f;

  localparam logic [CHAR_W-1:0] CHAR_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_LF  = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_CR  = 8'd13;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // classification of one queued command
  typedef struct packed {
    logic is_read;
    logic in_range;
    logic glyph;
    logic scroll;
  } cmd_flags_t;

  localparam int FLAGS_W = $bits(cmd_flags_t);

endpackage

`default_nettype wire

// ===== rtl/tcw_in_if.sv =====
`default_nettype none

interface tcw_in_if import tcw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [CHAR_W-1:0]  char_code;
  logic [INDEX_W-1:0] screen_index;

  modport source (output valid, op, char_code, screen_index, input ready);
  modport sink   (input valid, op, char_code, screen_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/tcw_out_if.sv =====
`default_nettype none

interface tcw_out_if import tcw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CELL_W-1:0]  cell_value;
  logic [INDEX_W-1:0] caret_index;
  logic               scrolled;

  modport source (output valid, cell_value, caret_index, scrolled, input ready);
  modport sink   (input valid, cell_value, caret_index, scrolled, output ready);
endinterface

`default_nettype wire

// ===== rtl/text_console_writer.sv =====
`default_nettype none

// Text console writer: a ROWS x COLS character screen held in a circular line
// store. A put transaction moves the caret (tab, newline, return) or stores a
// glyph with the current attribute; moving past the last row scrolls by
// blanking the top line in place. A read transaction returns the on-screen cell
// at a screen index, zero beyond the screen. Every transaction reports the
// caret's screen index. A front end classifies each transaction and updates the
// caret at once, then queues a command for the back end that owns the store.
// In the back end a put without scroll or an out-of-range read goes from idle to
// the output state, an in-range read passes through a wait state for the
// registered store read, and a scrolling put through a sweep state that writes
// the blank line one cell per cycle through the single write port; a new command
// is popped only once the last result has been taken. After reset the back end
// fills all ROWS*COLS cells of the store with 0x1f20 at one cell per cycle,
// during which in_i.ready stays low; attribute writes are taken throughout.
module text_console_writer import tcw_pkg::*; #(
  parameter int ROWS        = TCW_ROWS,
  parameter int COLS        = TCW_COLS,
  parameter int QUEUE_DEPTH = TCW_QUEUE_DEPTH
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              cfg_we_i,
  input  wire [ATTR_W-1:0] cfg_wdata_i,
  tcw_in_if.sink           in_i,
  tcw_out_if.source        out_o
);

  localparam int ADDR_W = $clog2(ROWS * COLS);
  localparam int DW     = FLAGS_W + 2 * ADDR_W + CHAR_W + INDEX_W;

  logic               push, full, clearing, q_valid, q_pop;
  cmd_flags_t         f_flags, b_flags;
  logic [ADDR_W-1:0]  f_addr, f_base, b_addr, b_base;
  logic [CHAR_W-1:0]  f_char, b_char;
  logic [INDEX_W-1:0] f_caret, b_caret;
  logic [DW-1:0]      q_in, q_out;

  tcw_front #(.ROWS(ROWS), .COLS(COLS)) u_front (
    .clk_i,
    .rst_ni,
    .in_i,
    .full_i     (full),
    .clearing_i (clearing),
    .push_o     (push),
    .flags_o    (f_flags),
    .addr_o     (f_addr),
    .base_o     (f_base),
    .char_o     (f_char),
    .caret_o    (f_caret)
  );

  assign q_in = {f_flags, f_addr, f_base, f_char, f_caret};

  tcw_cmd_fifo #(.DW(DW), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .data_i  (q_in),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  assign {b_flags, b_addr, b_base, b_char, b_caret} = q_out;

  tcw_back #(.ROWS(ROWS), .COLS(COLS)) u_back (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .valid_i    (q_valid),
    .pop_o      (q_pop),
    .flags_i    (b_flags),
    .addr_i     (b_addr),
    .base_i     (b_base),
    .char_i     (b_char),
    .caret_i    (b_caret),
    .clearing_o (clearing),
    .out_o
  );

endmodule

`default_nettype wire

// ===== rtl/tcw_front.sv =====
`default_nettype none

module tcw_front import tcw_pkg::*; #(
  parameter int ROWS = TCW_ROWS,
  parameter int COLS = TCW_COLS,
  localparam int CELLS  = ROWS * COLS,
  localparam int ADDR_W = $clog2(CELLS),
  localparam int ROW_W  = (ROWS > 2) ? $clog2(ROWS) : 1,
  localparam int COL_W  = $clog2(COLS)
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  tcw_in_if.sink            in_i,
  input  wire               full_i,
  input  wire               clearing_i,
  output logic              push_o,
  output cmd_flags_t        flags_o,
  output logic [ADDR_W-1:0] addr_o,
  output logic [ADDR_W-1:0] base_o,
  output logic [CHAR_W-1:0] char_o,
  output logic [INDEX_W-1:0] caret_o
);

  localparam logic [ADDR_W:0]  CELLS_X = (ADDR_W+1)'(CELLS);
  localparam logic [ADDR_W:0]  COLS_X  = (ADDR_W+1)'(COLS);
  localparam logic [COL_W:0]   COLS_C  = (COL_W+1)'(COLS);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ADDR_W-1:0] row_base_q, row_base_d;
  logic [ADDR_W-1:0] top_base_q, top_base_d;

  logic [COL_W:0]    tab_sum, ncol;
  logic              row_inc, glyph, scroll, is_put;
  logic [ADDR_W:0]   top_next;
  logic [ADDR_W-1:0] caret_old, caret_new, new_row_base;

  // screen-linear index to physical store address under the current top line
  function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W:0] lin,
                                             input logic [ADDR_W-1:0] top);
    logic [ADDR_W:0] sum;
    sum = (ADDR_W+1)'(top) + lin;
    if (sum >= CELLS_X) begin
      sum = sum - CELLS_X;
    end
    return ADDR_W'(sum);
  endfunction

  assign in_i.ready = !full_i && !clearing_i;
  assign push_o     = in_i.valid && in_i.ready;
  assign is_put     = (in_i.op == OP_PUT);

  always_comb begin
    tab_sum = (COL_W+1)'(col_q) + (COL_W+1)'(8);
    ncol    = (COL_W+1)'(col_q);
    row_inc = 1'b0;
    glyph   = 1'b0;
    case (in_i.char_code)
      CHAR_TAB: ncol = {tab_sum[COL_W:3], 3'b000};
      CHAR_LF: begin
        ncol    = '0;
        row_inc = 1'b1;
      end
      CHAR_CR: ncol = '0;
      default: begin
        ncol  = (COL_W+1)'(col_q) + (COL_W+1)'(1);
        glyph = 1'b1;
      end
    endcase
    if (ncol >= COLS_C) begin
      ncol    = ncol - COLS_C;
      row_inc = 1'b1;
    end
    scroll = row_inc && (row_q == LAST_ROW);
  end

  assign top_next     = (ADDR_W+1)'(top_base_q) + COLS_X;
  assign new_row_base = (row_inc && !scroll) ? ADDR_W'(row_base_q + ADDR_W'(COLS)) : row_base_q;
  assign caret_old    = row_base_q + ADDR_W'(col_q);
  assign caret_new    = new_row_base + ADDR_W'(ncol);

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    row_base_d = row_base_q;
    top_base_d = top_base_q;
    if (push_o && is_put) begin
      col_d      = COL_W'(ncol);
      row_base_d = new_row_base;
      if (row_inc && !scroll) begin
        row_d = row_q + ROW_W'(1);
      end
      if (scroll) begin
        top_base_d = (top_next >= CELLS_X) ? '0 : ADDR_W'(top_next);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      row_base_q <= '0;
      top_base_q <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      row_base_q <= row_base_d;
      top_base_q <= top_base_d;
    end
  end

  always_comb begin
    flags_o.is_read  = !is_put;
    flags_o.in_range = (32'(in_i.screen_index) < 32'(CELLS));
    flags_o.glyph    = is_put && glyph;
    flags_o.scroll   = is_put && scroll;
    addr_o  = is_put ? phys((ADDR_W+1)'(caret_old), top_base_q)
                     : phys((ADDR_W+1)'(in_i.screen_index), top_base_q);
    base_o  = top_base_q;
    char_o  = in_i.char_code;
    caret_o = is_put ? INDEX_W'(caret_new) : INDEX_W'(caret_old);
  end

endmodule

`default_nettype wire

// ===== rtl/tcw_cmd_fifo.sv =====
`default_nettype none

module tcw_cmd_fifo import tcw_pkg::*; #(
  parameter int DW    = 8,
  parameter int DEPTH = TCW_QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           push_i,
  input  wire  [DW-1:0] data_i,
  output logic          full_o,
  input  wire           pop_i,
  output logic          valid_o,
  output logic [DW-1:0] data_o
);

  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [DW-1:0]    slot_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tcw_back.sv =====
`default_nettype none

module tcw_back import tcw_pkg::*; #(
  parameter int ROWS = TCW_ROWS,
  parameter int COLS = TCW_COLS,
  localparam int CELLS  = ROWS * COLS,
  localparam int ADDR_W = $clog2(CELLS),
  localparam int COL_W  = $clog2(COLS)
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire  [ATTR_W-1:0]  cfg_wdata_i,
  input  wire                valid_i,
  output logic               pop_o,
  input  wire  cmd_flags_t   flags_i,
  input  wire  [ADDR_W-1:0]  addr_i,
  input  wire  [ADDR_W-1:0]  base_i,
  input  wire  [CHAR_W-1:0]  char_i,
  input  wire  [INDEX_W-1:0] caret_i,
  output logic               clearing_o,
  tcw_out_if.source          out_o
);

  typedef enum logic [4:0] {
    BK_CLEAR  = 5'b00001,
    BK_IDLE   = 5'b00010,
    BK_SWEEP  = 5'b00100,
    BK_RDWAIT = 5'b01000,
    BK_OUT    = 5'b10000
  } back_state_e;

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLS - 1);

  back_state_e state_q, state_d;
  logic [ATTR_W-1:0]  attr_q;
  logic [ADDR_W-1:0]  clr_cnt_q, clr_cnt_d;
  logic [COL_W-1:0]   col_cnt_q, col_cnt_d;
  logic [ADDR_W-1:0]  base_q, base_d;
  logic [CELL_W-1:0]  cell_q, cell_d;
  logic [INDEX_W-1:0] caret_q, caret_d;
  logic               scrolled_q, scrolled_d;

  logic [CELL_W-1:0]  store_q [CELLS];
  logic [CELL_W-1:0]  rdata_q;
  logic               we, re;
  logic [ADDR_W-1:0]  waddr;
  logic [CELL_W-1:0]  wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      store_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= store_q[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  assign pop_o      = (state_q == BK_IDLE) && valid_i;
  assign clearing_o = (state_q == BK_CLEAR);

  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    col_cnt_d  = col_cnt_q;
    base_d     = base_q;
    cell_d     = cell_q;
    caret_d    = caret_q;
    scrolled_d = scrolled_q;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = addr_i;
    wdata      = {attr_q, char_i};
    unique case (state_q)
      BK_CLEAR: begin
        we        = 1'b1;
        waddr     = clr_cnt_q;
        wdata     = RESET_CELL;
        clr_cnt_d = clr_cnt_q + ADDR_W'(1);
        if (clr_cnt_q == LAST_CELL) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (valid_i) begin
          caret_d    = caret_i;
          scrolled_d = flags_i.scroll;
          cell_d     = '0;
          base_d     = base_i;
          col_cnt_d  = '0;
          // glyph cell never lies in the line a scroll blanks, unless ROWS is 1
          we = flags_i.glyph;
          if (flags_i.is_read && flags_i.in_range) begin
            re      = 1'b1;
            state_d = BK_RDWAIT;
          end else if (flags_i.scroll) begin
            state_d = BK_SWEEP;
          end else begin
            state_d = BK_OUT;
          end
        end
      end
      BK_SWEEP: begin
        we        = 1'b1;
        waddr     = base_q + ADDR_W'(col_cnt_q);
        wdata     = {attr_q, BLANK_GLYPH};
        col_cnt_d = col_cnt_q + COL_W'(1);
        if (col_cnt_q == LAST_COL) begin
          state_d = BK_OUT;
        end
      end
      BK_RDWAIT: begin
        cell_d  = rdata_q;
        state_d = BK_OUT;
      end
      BK_OUT: begin
        if (out_o.ready) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_CLEAR;
      clr_cnt_q <= '0;
      col_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      col_cnt_q <= col_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    cell_q     <= cell_d;
    caret_q    <= caret_d;
    scrolled_q <= scrolled_d;
  end

  assign out_o.valid       = (state_q == BK_OUT);
  assign out_o.cell_value  = cell_q;
  assign out_o.caret_index = caret_q;
  assign out_o.scrolled    = scrolled_q;

endmodule

`default_nettype wire

// ===== rtl/tcw_checker.sv =====
`default_nettype none

module tcw_checker import tcw_pkg::*; #(
  parameter int ROWS = TCW_ROWS,
  parameter int COLS = TCW_COLS
) (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               in_ready,
  input wire               out_valid,
  input wire               out_ready,
  input wire [CELL_W-1:0]  cell_value,
  input wire [INDEX_W-1:0] caret_index,
  input wire               scrolled
);

  localparam int  CELLS    = ROWS * COLS;
  localparam bit  NARROW   = (CELLS <= (1 << INDEX_W));
  localparam logic [INDEX_W:0] CELLS_X     = (INDEX_W+1)'(CELLS);
  localparam logic [INDEX_W:0] LAST_ROW_AT = (INDEX_W+1)'((ROWS - 1) * COLS);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(cell_value)
      && $stable(caret_index) && $stable(scrolled))
    else $error("result changed while stalled");

  // a scroll only comes from a put and leaves the caret on the last row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && scrolled |-> cell_value == '0
      && (!NARROW || {1'b0, caret_index} >= LAST_ROW_AT))
    else $error("scroll result inconsistent");

  // caret stays on screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && NARROW |-> {1'b0, caret_index} < CELLS_X)
    else $error("caret off screen");

  // store fill runs right after reset, so no transaction is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready)
    else $error("input taken during store fill");

endmodule

bind text_console_writer tcw_checker #(.ROWS(ROWS), .COLS(COLS)) u_tcw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .cell_value  (out_o.cell_value),
  .caret_index (out_o.caret_index),
  .scrolled    (out_o.scrolled)
);

`default_nettype wire
